### hdl/deq_pkg.sv
// Shared types and defaults for the double-ended queue unit.
// No dependencies; imported by double_ended_queue_unit.
package deq_pkg;

   localparam int DEFAULT_CAPACITY   = 64;
   localparam int DEFAULT_VALUE_BITS = 64;

   typedef enum logic [2:0] {
      OP_PUSH_BACK  = 3'd0,
      OP_PUSH_FRONT = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_REVERSE    = 3'd4,
      OP_CLEAR      = 3'd5,
      OP_PEEK       = 3'd6
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

endpackage

### hdl/double_ended_queue_unit.sv
// Double-ended queue over a ring of slots held in an on-chip memory.
// Depends on deq_pkg for the operation and status codes and defaults.
//
//   channel   ports                                    handshake
//   -------   --------------------------------------   -------------------------
//   request   req_op, req_value                        start high, busy low
//   response  rsp_front_value, rsp_back_value,         rsp_valid, one cycle,
//             rsp_count, rsp_status                    no back-pressure
//
// One request per cycle; busy is always low. The response comes in the cycle
// after the request edge: state, slot write and both end reads happen at that
// edge, the two registered read ports of the slot memory set the latency.
// A word pushed at the same edge is forwarded around the memory.
// Reset clears head, count and direction; slot contents are never cleared.
module double_ended_queue_unit
   import deq_pkg::*;
#(
   parameter int CAPACITY   = DEFAULT_CAPACITY,
   parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [2:0]                    req_op,
   input  logic [VALUE_BITS-1:0]         req_value,
   output logic                          rsp_valid,
   output logic [VALUE_BITS-1:0]         rsp_front_value,
   output logic [VALUE_BITS-1:0]         rsp_back_value,
   output logic [$clog2(CAPACITY+1)-1:0] rsp_count,
   output logic [1:0]                    rsp_status
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int SUM_W = CNT_W + 1;

   logic [VALUE_BITS-1:0] slots_ff [CAPACITY];

   logic [IDX_W-1:0]      head_ff, head_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  rev_ff, rev_in;
   status_type            status_ff, status_in;
   logic                  valid_ff;

   logic [VALUE_BITS-1:0] front_rd_ff, back_rd_ff, wdata_ff;
   logic                  front_byp_ff, back_byp_ff;

   op_type                op;
   logic                  empty, full;
   logic [IDX_W-1:0]      head_inc, head_dec, tail_pos;
   logic [SUM_W-1:0]      tail_sum, tail_wrap;
   logic [SUM_W-1:0]      back_sum, back_m1, back_wrap;
   logic [IDX_W-1:0]      front_addr, back_addr;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   logic [VALUE_BITS-1:0] phys_front, phys_back;

   assign busy = 1'b0;

   always_comb begin
      op       = op_type'(req_op);
      empty    = (count_ff == '0);
      full     = (count_ff == CNT_W'(CAPACITY));
      head_inc = (head_ff == IDX_W'(CAPACITY - 1)) ? '0 : head_ff + 1'b1;
      head_dec = (head_ff == '0) ? IDX_W'(CAPACITY - 1) : head_ff - 1'b1;

      // slot just past the physical back
      tail_sum  = SUM_W'(head_ff) + SUM_W'(count_ff);
      tail_wrap = (tail_sum >= SUM_W'(CAPACITY)) ? tail_sum - SUM_W'(CAPACITY) : tail_sum;
      tail_pos  = tail_wrap[IDX_W-1:0];

      head_in   = head_ff;
      count_in  = count_ff;
      rev_in    = rev_ff;
      status_in = ST_OK;
      wr_en     = 1'b0;
      wr_addr   = tail_pos;

      case (op)
         OP_PUSH_BACK, OP_PUSH_FRONT: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + 1'b1;
               if ((op == OP_PUSH_BACK) != rev_ff) begin
                  wr_addr = tail_pos;
               end else begin
                  wr_addr = head_dec;
                  head_in = head_dec;
               end
            end
         end
         OP_POP_FRONT, OP_POP_BACK: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               count_in = count_ff - 1'b1;
               if ((op == OP_POP_FRONT) != rev_ff) begin
                  head_in = head_inc;
               end
            end
         end
         OP_REVERSE: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               rev_in = ~rev_ff;
            end
         end
         OP_CLEAR: begin
            head_in  = '0;
            count_in = '0;
            rev_in   = 1'b0;
         end
         default: begin
            // peek, and the unused code behaves the same
            if (empty) begin
               status_in = ST_EMPTY;
            end
         end
      endcase

      // physical ends after the request; back is don't-care when empty
      front_addr = head_in;
      back_sum   = SUM_W'(head_in) + SUM_W'(count_in);
      back_m1    = (back_sum == '0) ? '0 : back_sum - 1'b1;
      back_wrap  = (back_m1 >= SUM_W'(CAPACITY)) ? back_m1 - SUM_W'(CAPACITY) : back_m1;
      back_addr  = back_wrap[IDX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         count_ff  <= '0;
         rev_ff    <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         valid_ff <= start;
         if (start) begin
            head_ff  <= head_in;
            count_ff <= count_in;
            rev_ff   <= rev_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start && wr_en) begin
         slots_ff[wr_addr] <= req_value;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         front_rd_ff  <= slots_ff[front_addr];
         back_rd_ff   <= slots_ff[back_addr];
         front_byp_ff <= wr_en && (wr_addr == front_addr);
         back_byp_ff  <= wr_en && (wr_addr == back_addr);
         wdata_ff     <= req_value;
         status_ff    <= status_in;
      end
   end

   always_comb begin
      phys_front = front_byp_ff ? wdata_ff : front_rd_ff;
      phys_back  = back_byp_ff  ? wdata_ff : back_rd_ff;
      if (count_ff == '0) begin
         phys_front = '0;
         phys_back  = '0;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_front_value = rev_ff ? phys_back  : phys_front;
   assign rsp_back_value  = rev_ff ? phys_front : phys_back;
   assign rsp_count       = count_ff;
   assign rsp_status      = status_ff;

endmodule
